// File: design/sheu_pkg.sv
// Package with the sequencer states and hash constants of the shingle hash embedding unit.
package sheu_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_MOD,
    S_UPD_RD,
    S_UPD_WR,
    S_SUM_RD,
    S_SUM_MUL,
    S_SUM_ACC,
    S_NRM_RD,
    S_NRM_MUL,
    S_DIV_INIT,
    S_DIV,
    S_SQRT,
    S_OUT
  } state_t;

endpackage

// File: design/shingle_hash_embedding_unit.sv
// Top level of the shingle hash embedding unit: hashing, histogram and normalization.
//
// Text bytes arrive one transaction at a time. A byte that completes a four-byte window
// takes four passes through the shared 32x32 multiplier for FNV-1a, a 32-step
// bit-serial remainder by the bucket count, and a read-modify-write of the histogram
// memory; other bytes are only taken into the window. A byte marked last then forms
// the sum of squares bucket by bucket, and each output value takes one
// square on the same multiplier, a 35-step restoring division and an 18-step integer
// square root. The block takes no input while it works and while a result waits.
// The histogram is cleared at once through per-bucket valid bits, so no clearing pass.
module shingle_hash_embedding_unit #(
  parameter int MAX_BUCKETS = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  bucket_index,
  output logic [16:0] norm_value,
  output logic        last_value,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);
  import sheu_pkg::*;

  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SW = 2 * COUNT_BITS + 7;
  localparam int CW = 2 * COUNT_BITS;

  state_t state, state_next;
  logic [6:0]  k, k_next;
  logic [5:0]  step, step_next;
  logic [63:0] prod, prod_next;
  logic [SW-1:0] rem, rem_next;
  logic [35:0] qsh, qsh_next;
  logic [20:0] srem, srem_next;
  logic [17:0] root, root_next;
  logic [31:0] wbuf, wbuf_next;
  logic        last_q, last_q_next;
  logic [23:0] recent, recent_next;
  logic [1:0]  seen, seen_next;
  logic [MAX_BUCKETS-1:0] vld, vld_next;
  logic [6:0]  dim_reg;
  logic [6:0]  dim;
  logic [SW-1:0] sum, sum_next;
  logic [6:0]  mrem, mrem_next;
  logic        c2lsb, c2lsb_next;
  logic [16:0] nv, nv_next;

  logic [COUNT_BITS-1:0] mem [MAX_BUCKETS];
  logic [COUNT_BITS-1:0] mem_q;
  logic        vld_q;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] cnt;
  logic        mul_en;
  logic [31:0] mul_a, mul_b;

  logic [7:0]  m2;
  logic [SW:0] d2;
  logic [20:0] sr2, trial;
  logic [18:0] rnd;

  always_comb begin
    if (dim_reg == 7'd0) begin
      dim = 7'd1;
    end else if (dim_reg > 7'(MAX_BUCKETS)) begin
      dim = 7'(MAX_BUCKETS);
    end else begin
      dim = dim_reg;
    end
  end

  assign cnt          = vld_q ? mem_q : '0;
  assign in_stall     = (state != S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign bucket_index = k[5:0];
  assign last_value   = ((k + 7'd1) == dim);
  assign norm_value   = nv;

  always_comb begin
    state_next  = state;
    k_next      = k;
    step_next   = step;
    prod_next   = prod;
    rem_next    = rem;
    qsh_next    = qsh;
    srem_next   = srem;
    root_next   = root;
    wbuf_next   = wbuf;
    last_q_next = last_q;
    recent_next = recent;
    seen_next   = seen;
    vld_next    = vld;
    sum_next    = sum;
    mrem_next   = mrem;
    c2lsb_next  = c2lsb;
    nv_next     = nv;
    rd_addr     = k[AW-1:0];
    wr_en       = 1'b0;
    wr_data     = (cnt == '1) ? cnt : cnt + 1'b1;
    mul_en      = 1'b0;
    mul_a       = 32'(cnt);
    mul_b       = 32'(cnt);
    m2          = {mrem, prod[31]};
    d2          = {rem, ((step == 6'd0) ? c2lsb : 1'b0)};
    sr2         = {srem[18:0], qsh[35:34]};
    trial       = {1'b0, root, 2'b01};
    rnd         = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          wbuf_next   = {recent, text_byte};
          recent_next = {recent[15:0], text_byte};
          last_q_next = last_byte;
          if (seen == 2'd3) begin
            step_next  = 6'd0;
            state_next = S_HASH;
          end else begin
            seen_next = seen + 2'd1;
            if (last_byte) begin
              k_next     = 7'd0;
              sum_next   = '0;
              state_next = S_SUM_RD;
            end
          end
        end
      end
      S_HASH: begin
        mul_en    = 1'b1;
        mul_a     = ((step == 6'd0) ? FNV_BASIS : prod[31:0]) ^ {24'd0, wbuf[31:24]};
        mul_b     = FNV_PRIME;
        wbuf_next = {wbuf[23:0], 8'd0};
        step_next = step + 6'd1;
        if (step == 6'd3) begin
          step_next  = 6'd0;
          mrem_next  = 7'd0;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        mrem_next = (m2 >= {1'b0, dim}) ? 7'(m2 - {1'b0, dim}) : m2[6:0];
        prod_next = {prod[62:0], 1'b0};
        step_next = step + 6'd1;
        if (step == 6'd31) begin
          state_next = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        rd_addr    = mrem[AW-1:0];
        state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        rd_addr                = mrem[AW-1:0];
        wr_en                  = 1'b1;
        vld_next[mrem[AW-1:0]] = 1'b1;
        if (last_q) begin
          k_next     = 7'd0;
          sum_next   = '0;
          state_next = S_SUM_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUM_RD: begin
        state_next = S_SUM_MUL;
      end
      S_SUM_MUL: begin
        mul_en     = 1'b1;
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        sum_next = sum + SW'(prod[CW-1:0]);
        if ((k + 7'd1) == dim) begin
          k_next = 7'd0;
          state_next = S_NRM_RD;
        end else begin
          k_next = k + 7'd1;
          state_next = S_SUM_RD;
        end
      end
      S_NRM_RD: begin
        state_next = S_NRM_MUL;
      end
      S_NRM_MUL: begin
        mul_en     = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        rem_next   = SW'(prod[CW-1:1]);
        c2lsb_next = prod[0];
        qsh_next   = '0;
        step_next  = 6'd0;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (d2 >= {1'b0, sum}) begin
          rem_next = SW'(d2 - {1'b0, sum});
          qsh_next = {qsh[34:0], 1'b1};
        end else begin
          rem_next = d2[SW-1:0];
          qsh_next = {qsh[34:0], 1'b0};
        end
        step_next = step + 6'd1;
        if (step == 6'd34) begin
          step_next  = 6'd0;
          srem_next  = '0;
          root_next  = '0;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sr2 >= trial) begin
          srem_next = sr2 - trial;
          root_next = {root[16:0], 1'b1};
        end else begin
          srem_next = sr2;
          root_next = {root[16:0], 1'b0};
        end
        qsh_next  = {qsh[33:0], 2'b00};
        step_next = step + 6'd1;
        if (step == 6'd17) begin
          rnd        = ({1'b0, root_next} + 19'd1) >> 1;
          nv_next    = (sum == '0) ? 17'd0 : rnd[16:0];
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if ((k + 7'd1) == dim) begin
            vld_next    = '0;
            seen_next   = 2'd0;
            recent_next = '0;
            state_next  = S_IDLE;
          end else begin
            k_next     = k + 7'd1;
            state_next = S_NRM_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (mul_en) begin
      prod_next = mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      k       <= 7'd0;
      step    <= 6'd0;
      last_q  <= 1'b0;
      recent  <= '0;
      seen    <= 2'd0;
      vld     <= '0;
      dim_reg <= 7'd64;
    end else begin
      state  <= state_next;
      k      <= k_next;
      step   <= step_next;
      last_q <= last_q_next;
      recent <= recent_next;
      seen   <= seen_next;
      vld    <= vld_next;
      if (cfg_we) begin
        dim_reg <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= prod_next;
    rem   <= rem_next;
    qsh   <= qsh_next;
    srem  <= srem_next;
    root  <= root_next;
    wbuf  <= wbuf_next;
    sum   <= sum_next;
    mrem  <= mrem_next;
    c2lsb <= c2lsb_next;
    nv    <= nv_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mrem[AW-1:0]] <= wr_data;
    end
    mem_q <= mem[rd_addr];
    vld_q <= vld[rd_addr];
  end

endmodule
